>>> rtl/pbnfl_pkg.sv
// ----------------------------------------------------------------------------
// pbnfl_pkg
// Shared types and constants of the protobuf nested field locator.
// ----------------------------------------------------------------------------
package pbnfl_pkg;

  localparam int unsigned PathDepthDefault = 6;
  localparam int unsigned BufferBytes      = 1048576;
  localparam int unsigned VarintMaxBytes   = 10;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = 21;
  localparam int unsigned LenW     = 64;
  localparam int unsigned TagW     = 32;
  localparam int unsigned FieldW   = 29;
  localparam int unsigned PathLenW = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned VbW      = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 29;
  localparam int unsigned OutDataW = 120;

  localparam logic [CfgIdxW-1:0] CfgPathLen    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPathField0 = 3'd1;

  localparam logic [2:0] WireTypeLen = 3'd2;

  typedef enum logic [StatusW-1:0] {
    StFound    = 2'd0,
    StNonLen   = 2'd1,
    StEnded    = 2'd2,
    StOverlong = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             is_last;
  } item_t;

  typedef struct packed {
    status_e             status;
    logic [PosW-1:0]     content_offset;
    logic [LenW-1:0]     field_length;
    logic [TagW-1:0]     matched_tag;
    logic [PathLenW-1:0] depth_reached;
  } result_t;

endpackage

>>> rtl/pbnfl_cfg.sv
// ----------------------------------------------------------------------------
// pbnfl_cfg
// Search path registers: path length and one field number per depth.
// ----------------------------------------------------------------------------
module pbnfl_cfg import pbnfl_pkg::*; #(
  parameter int unsigned PATH_DEPTH = PathDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic [PathLenW-1:0] path_len_o,
  output logic [FieldW-1:0]   path_field_o [PATH_DEPTH]
);

  logic [PathLenW-1:0] path_len_q;
  logic [FieldW-1:0]   path_field_q [PATH_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_len_q <= '0;
      for (int k = 0; k < PATH_DEPTH; k++) begin
        path_field_q[k] <= FieldW'(1);
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgPathLen) begin
        path_len_q <= cfg_data_i[PathLenW-1:0];
      end
      for (int k = 0; k < PATH_DEPTH; k++) begin
        if (cfg_idx_i == CfgIdxW'(int'(CfgPathField0) + k)) begin
          path_field_q[k] <= cfg_data_i[FieldW-1:0];
        end
      end
    end
  end

  assign path_len_o   = path_len_q;
  assign path_field_o = path_field_q;

endmodule

>>> rtl/pbnfl_in_stage.sv
// ----------------------------------------------------------------------------
// pbnfl_in_stage
// Input register: holds one buffer byte until the walker steps on it.
// ----------------------------------------------------------------------------
module pbnfl_in_stage import pbnfl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  out_free_i,
  output logic  step_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign step_o     = valid_q & out_free_i;
  assign in_ready_o = ~valid_q | step_o;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

>>> rtl/pbnfl_walker.sv
// ----------------------------------------------------------------------------
// pbnfl_walker
// Wire-format walk state: varint accumulation, tag match, skip count.
// ----------------------------------------------------------------------------
module pbnfl_walker import pbnfl_pkg::*; #(
  parameter int unsigned PATH_DEPTH = PathDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  item_t               item_i,
  input  logic [PathLenW-1:0] path_len_i,
  input  logic [FieldW-1:0]   path_field_i [PATH_DEPTH],
  output logic                res_valid_o,
  output result_t             res_o
);

  localparam int unsigned IdxW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;

  typedef enum logic [1:0] {
    PhLen     = 2'd0,
    PhTag     = 2'd1,
    PhSkipLen = 2'd2,
    PhSkip    = 2'd3
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [LenW-1:0]     accum_q, accum_d;
  logic [VbW-1:0]      bytes_q, bytes_d;
  logic [PathLenW-1:0] pidx_q, pidx_d;
  logic [LenW-1:0]     skip_q, skip_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic                over_q, over_d;
  logic [TagW-1:0]     tag_q, tag_d;

  logic [LenW-1:0]     ins;
  logic [LenW-1:0]     accum_v;
  logic [PathLenW-1:0] active_len;
  logic [PathLenW-1:0] idx_full;
  logic [IdxW-1:0]     sel;
  logic                tag_hit;

  assign active_len = (path_len_i > PathLenW'(PATH_DEPTH)) ? PathLenW'(PATH_DEPTH) : path_len_i;
  assign idx_full   = (pidx_q < PathLenW'(PATH_DEPTH)) ? pidx_q : PathLenW'(PATH_DEPTH - 1);
  assign sel        = idx_full[IdxW-1:0];

  always_comb begin
    ins = '0;
    for (int k = 0; k < VarintMaxBytes; k++) begin
      if (bytes_q == VbW'(k)) begin
        ins = LenW'(item_i.data_byte[6:0]) << (7 * k);
      end
    end
  end

  assign accum_v = accum_q | ins;
  assign tag_hit = (accum_v[LenW-1:TagW] == '0) &&
                   (accum_v[TagW-1:3] == path_field_i[sel]);

  always_comb begin
    phase_d     = phase_q;
    accum_d     = accum_q;
    bytes_d     = bytes_q;
    pidx_d      = pidx_q;
    skip_d      = skip_q;
    pos_d       = pos_q;
    over_d      = over_q;
    tag_d       = tag_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      if (!over_q) begin
        if (pos_q < PosW'(BufferBytes)) begin
          pos_d = pos_q + 1'b1;
        end
        if (phase_q == PhSkip) begin
          skip_d = skip_q - 1'b1;
          if (skip_q == LenW'(1)) begin
            phase_d = PhTag;
          end
        end else if (item_i.data_byte[7]) begin
          accum_d = accum_v;
          bytes_d = bytes_q + 1'b1;
          if (bytes_d >= VbW'(VarintMaxBytes)) begin
            res_valid_o       = 1'b1;
            res_o.status      = StOverlong;
            res_o.matched_tag = tag_q;
            res_o.depth_reached = pidx_q;
            over_d            = 1'b1;
          end
        end else begin
          accum_d = '0;
          bytes_d = '0;
          unique case (phase_q)
            PhLen: begin
              if (pidx_q >= active_len) begin
                res_valid_o          = 1'b1;
                res_o.status         = StFound;
                res_o.content_offset = pos_d;
                res_o.field_length   = accum_v;
                res_o.matched_tag    = tag_q;
                res_o.depth_reached  = pidx_q;
                over_d               = 1'b1;
              end else begin
                phase_d = PhTag;
              end
            end
            PhTag: begin
              if (tag_hit) begin
                tag_d   = accum_v[TagW-1:0];
                pidx_d  = pidx_q + 1'b1;
                phase_d = PhLen;
              end else if (accum_v[2:0] == WireTypeLen) begin
                phase_d = PhSkipLen;
              end else begin
                res_valid_o         = 1'b1;
                res_o.status        = StNonLen;
                res_o.matched_tag   = tag_q;
                res_o.depth_reached = pidx_q;
                over_d              = 1'b1;
              end
            end
            PhSkipLen: begin
              skip_d  = accum_v;
              phase_d = (accum_v == '0) ? PhTag : PhSkip;
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
      if (item_i.is_last) begin
        if (!over_d) begin
          res_valid_o         = 1'b1;
          res_o               = '0;
          res_o.status        = StEnded;
          res_o.matched_tag   = tag_d;
          res_o.depth_reached = pidx_d;
        end
        phase_d = PhLen;
        accum_d = '0;
        bytes_d = '0;
        pidx_d  = '0;
        skip_d  = '0;
        pos_d   = '0;
        over_d  = 1'b0;
        tag_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLen;
      accum_q <= '0;
      bytes_q <= '0;
      pidx_q  <= '0;
      skip_q  <= '0;
      pos_q   <= '0;
      over_q  <= 1'b0;
      tag_q   <= '0;
    end else begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      bytes_q <= bytes_d;
      pidx_q  <= pidx_d;
      skip_q  <= skip_d;
      pos_q   <= pos_d;
      over_q  <= over_d;
      tag_q   <= tag_d;
    end
  end

`ifndef ASSERT_OFF
  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.is_last |=> pidx_q == '0 && pos_q == '0 && !over_q && phase_q == PhLen)
    else $error("walk state not restarted after last byte");

  a_quiet_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    over_q && !item_i.is_last |-> !res_valid_o)
    else $error("result after search ended");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pidx_q <= PathLenW'(PATH_DEPTH))
    else $error("path index beyond path depth");

  a_varint_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !over_q |-> bytes_q < VbW'(VarintMaxBytes))
    else $error("varint byte count overran while search open");
`endif

endmodule

>>> rtl/pbnfl_out_stage.sv
// ----------------------------------------------------------------------------
// pbnfl_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module pbnfl_out_stage import pbnfl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign free_o      = ~valid_q | out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= res_i;
    end
  end

endmodule

>>> rtl/protobuf_nested_field_locator.sv
// ----------------------------------------------------------------------------
// protobuf_nested_field_locator
// Walks a protobuf buffer byte by byte toward a nested field path.
//
// Channel   Dir  Handshake               Content
// s_axis    in   tvalid/tready           tdata: data_byte, tlast: is_last
// m_axis    out  tvalid/tready           tdata: result fields, tuser: status
// cfg       in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// One byte per cycle sustained unless m_axis stalls; the walk state is registered.
// A result is registered onto m_axis as its byte steps out of the input stage.
// Reset clears the walk state and sets path_len 0, every path field 1.
// m_axis_tready low holds the result; s_axis takes at most one more byte, then stalls.
// ----------------------------------------------------------------------------
module protobuf_nested_field_locator import pbnfl_pkg::*; #(
  parameter int unsigned PATH_DEPTH = PathDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [20:0] content_offset,
                                              // [84:21] field_length,
                                              // [116:85] matched_tag,
                                              // [119:117] depth_reached
  output logic [StatusW-1:0]  m_axis_tuser,   // [1:0] status
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [PathLenW-1:0] path_len;
  logic [FieldW-1:0]   path_field [PATH_DEPTH];
  item_t               in_item;
  item_t               item;
  logic                step;
  logic                out_free;
  logic                res_valid;
  result_t             res;
  result_t             out_res;

  assign in_item.data_byte = s_axis_tdata;
  assign in_item.is_last   = s_axis_tlast;

  pbnfl_cfg #(.PATH_DEPTH(PATH_DEPTH)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .path_len_o  (path_len),
    .path_field_o(path_field)
  );

  pbnfl_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_item_i (in_item),
    .out_free_i(out_free),
    .step_o    (step),
    .item_o    (item)
  );

  pbnfl_walker #(.PATH_DEPTH(PATH_DEPTH)) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .path_len_i  (path_len),
    .path_field_i(path_field),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pbnfl_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step & res_valid),
    .res_i      (res),
    .free_o     (out_free),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .res_o      (out_res)
  );

  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {out_res.depth_reached, out_res.matched_tag,
                         out_res.field_length, out_res.content_offset};

endmodule

>>> verif/protobuf_nested_field_locator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// protobuf_nested_field_locator_test
// Feeds protobuf buffers one byte per item through the locator and checks
// every report against a behavioral walk of the same path, over several
// path settings and under sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module protobuf_nested_field_locator_test;
  import pbnfl_pkg::*;

  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned PhaseBytes    = 230;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned DirectedCount = 27;

  localparam logic [CfgIdxW-1:0] CfgPathField1 = CfgPathField0 + 3'd1;
  localparam logic [CfgIdxW-1:0] CfgUnknown    = 3'd7;

  typedef enum logic [1:0] {WalkLen, WalkTag, WalkSkipLen, WalkSkip} walk_e;
  typedef enum logic [1:0] {RowByte, RowPinned, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] value;
    logic                last;
    result_t             want;
  } step_row_t;

  localparam result_t NoResult = '0;

  localparam step_row_t DirectedRows [DirectedCount] = '{
    '{RowPinned, CfgPathLen, 29'h05, 1'b0, '{StFound, 21'd1, 64'd5, 32'd0, 3'd0}},
    '{RowByte,   CfgPathLen, 29'hAA, 1'b1, NoResult},
    '{RowPinned, CfgPathLen, 29'h80, 1'b1, '{StEnded, 21'd0, 64'd0, 32'd0, 3'd0}},
    '{RowByte,   CfgPathLen, 29'hFF, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'hFF, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'hFF, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'hFF, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'hFF, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'hFF, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'hFF, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'hFF, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'hFF, 1'b0, NoResult},
    '{RowPinned, CfgPathLen, 29'h01, 1'b1,
      '{StFound, 21'd10, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 3'd0}},
    '{RowCfg,    CfgPathLen,    29'd2,         1'b0, NoResult},
    '{RowCfg,    CfgPathField0, 29'h1FFF_FFFF, 1'b0, NoResult},
    '{RowCfg,    CfgPathField1, 29'd3,         1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'h03, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'h0A, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'h00, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'hF8, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'hFF, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'hFF, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'hFF, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'h0F, 1'b0, NoResult},
    '{RowByte,   CfgPathLen, 29'h02, 1'b0, NoResult},
    '{RowPinned, CfgPathLen, 29'h20, 1'b0,
      '{StNonLen, 21'd0, 64'd0, 32'hFFFF_FFF8, 3'd1}},
    '{RowByte,   CfgPathLen, 29'h00, 1'b1, NoResult}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata = '0;    // [7:0] data_byte
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // [20:0] content_offset,
                                             // [84:21] field_length,
                                             // [116:85] matched_tag,
                                             // [119:117] depth_reached
  logic [StatusW-1:0]  m_axis_tuser;         // [1:0] status
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;

  logic [PathLenW-1:0] cur_path_len;
  logic [FieldW-1:0]   cur_path_field [PathDepthDefault];

  walk_e               walk_state;
  logic [LenW-1:0]     varint_acc;
  logic [VbW-1:0]      varint_count;
  logic [PathLenW-1:0] path_depth;
  logic [LenW-1:0]     skip_left;
  logic [PosW-1:0]     byte_pos;
  logic                search_done;
  logic [TagW-1:0]     tag_hold;

  result_t    expected_results [$];
  logic [7:0] msg_bytes [$];

  protobuf_nested_field_locator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic int unsigned active_depth();
    return (cur_path_len > PathDepthDefault) ? PathDepthDefault : cur_path_len;
  endfunction

  function automatic void walk_restart();
    walk_state   = WalkLen;
    varint_acc   = '0;
    varint_count = '0;
    path_depth   = '0;
    skip_left    = '0;
    byte_pos     = '0;
    search_done  = 1'b0;
    tag_hold     = '0;
  endfunction

  function automatic void report(status_e st, logic [PosW-1:0] off, logic [LenW-1:0] len);
    result_t r;
    r.status         = st;
    r.content_offset = off;
    r.field_length   = len;
    r.matched_tag    = tag_hold;
    r.depth_reached  = path_depth;
    expected_results.push_back(r);
    search_done = 1'b1;
  endfunction

  function automatic void walk_byte(logic [7:0] b, logic last);
    logic [LenW-1:0] v;
    int unsigned     idx;
    if (!search_done) begin
      if (byte_pos < BufferBytes) byte_pos++;
      if (walk_state == WalkSkip) begin
        skip_left--;
        if (skip_left == 0) walk_state = WalkTag;
      end else begin
        if (varint_count < VarintMaxBytes) begin
          varint_acc |= 64'(b[6:0]) << (7 * varint_count);
        end
        if (b[7]) begin
          varint_count++;
          if (varint_count >= VarintMaxBytes) report(StOverlong, '0, '0);
        end else begin
          v = varint_acc;
          varint_acc = '0;
          varint_count = '0;
          case (walk_state)
            WalkLen: begin
              if (path_depth >= active_depth()) report(StFound, byte_pos, v);
              else walk_state = WalkTag;
            end
            WalkTag: begin
              idx = (path_depth < PathDepthDefault) ? path_depth : PathDepthDefault - 1;
              if ((v >> 3) == 64'(cur_path_field[idx])) begin
                tag_hold = v[TagW-1:0];
                path_depth++;
                walk_state = WalkLen;
              end else if (v[2:0] == WireTypeLen) begin
                walk_state = WalkSkipLen;
              end else begin
                report(StNonLen, '0, '0);
              end
            end
            default: begin
              skip_left = v;
              walk_state = (v == 0) ? WalkTag : WalkSkip;
            end
          endcase
        end
      end
    end
    if (last) begin
      if (!search_done) report(StEnded, '0, '0);
      walk_restart();
    end
  endfunction

  function automatic logic [FieldW-1:0] pick_field();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return FieldW'($urandom_range(1, 15));
    if (r < 8) return FieldW'($urandom_range(16, 4095));
    if (r < 9) return FieldW'($urandom_range(1, 29'h1FFF_FFFF));
    return 29'h1FFF_FFFF;
  endfunction

  function automatic logic [FieldW-1:0] other_field(int unsigned d);
    logic [FieldW-1:0] f;
    f = pick_field();
    if (f == cur_path_field[d]) f ^= 29'd1;
    return f;
  endfunction

  function automatic logic [LenW-1:0] pick_length();
    if ($urandom_range(0, 99) < 85) return 64'($urandom_range(0, 300));
    return {$urandom(), $urandom()};
  endfunction

  function automatic void append_varint(logic [LenW-1:0] v);
    logic [LenW-1:0] rest;
    rest = v;
    while (rest > 127) begin
      msg_bytes.push_back({1'b1, rest[6:0]});
      rest >>= 7;
    end
    msg_bytes.push_back({1'b0, rest[6:0]});
  endfunction

  function automatic void build_message();
    int unsigned kind, nlen, d, wt;
    bit          stopped;
    msg_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      append_varint(pick_length());
      stopped = 1'b0;
      for (d = 0; d < active_depth() && !stopped; d++) begin
        repeat ($urandom_range(0, 2)) begin
          append_varint({32'd0, other_field(d), WireTypeLen});
          nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
          append_varint(64'(nlen));
          repeat (nlen) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0) begin
          wt = $urandom_range(0, 6);
          if (wt >= WireTypeLen) wt++;
          append_varint({32'd0, other_field(d), 3'(wt)});
          stopped = 1'b1;
        end else begin
          wt = ($urandom_range(0, 9) < 8) ? int'(WireTypeLen) : $urandom_range(0, 7);
          append_varint({32'd0, cur_path_field[d], 3'(wt)});
          append_varint(pick_length());
        end
      end
      repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 84) begin
      if ($urandom_range(0, 1) == 1) append_varint(pick_length());
      repeat ($urandom_range(10, 12)) msg_bytes.push_back({1'b1, 7'($urandom_range(0, 127))});
    end else begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    walk_byte(b, last);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgPathLen) cur_path_len = value[PathLenW-1:0];
    else if (idx <= PathDepthDefault) cur_path_field[idx - 1] = value[FieldW-1:0];
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [LenW-1:0] want, logic [LenW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result: expected none, got status %0d", m_axis_tuser);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 64'(want.status), 64'(m_axis_tuser));
        check_field("content_offset", 64'(want.content_offset), 64'(m_axis_tdata[20:0]));
        check_field("field_length", want.field_length, m_axis_tdata[84:21]);
        check_field("matched_tag", 64'(want.matched_tag), 64'(m_axis_tdata[116:85]));
        check_field("depth_reached", 64'(want.depth_reached), 64'(m_axis_tdata[119:117]));
      end
    end
  end

  initial begin : stimulus
    step_row_t   r;
    int unsigned i, p, k, cut, sent;
    cur_path_len = '0;
    for (k = 0; k < PathDepthDefault; k++) cur_path_field[k] = 1;
    walk_restart();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DirectedCount; i++) begin
      r = DirectedRows[i];
      if (r.kind == RowCfg) begin
        wait_idle();
        write_reg(r.reg_idx, r.value);
      end else begin
        send_byte(r.value[7:0], r.last);
        if (r.kind == RowPinned) begin
          void'(expected_results.pop_back());
          expected_results.push_back(r.want);
        end
      end
    end

    for (p = 0; p < PhaseCount; p++) begin
      wait_idle();
      case (p)
        0: write_reg(CfgPathLen, 29'd0);
        1: write_reg(CfgPathLen, 29'd6);
        2: write_reg(CfgPathLen, 29'd7);
        3: write_reg(CfgPathLen, 29'd1);
        default: write_reg(CfgPathLen, 29'($urandom_range(1, 5)));
      endcase
      for (k = 0; k < PathDepthDefault; k++) begin
        case (p)
          1: write_reg(CfgPathField0 + 3'(k), (k % 2 == 1) ? 29'd1 : 29'h1FFF_FFFF);
          3: write_reg(CfgPathField0 + 3'(k), 29'd1);
          default: write_reg(CfgPathField0 + 3'(k), pick_field());
        endcase
      end
      if (p == 0) write_reg(CfgUnknown, 29'($urandom()));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      sent = 0;
      while (sent < PhaseBytes) begin
        build_message();
        cut = msg_bytes.size();
        if ($urandom_range(0, 99) < 12) cut = $urandom_range(1, msg_bytes.size());
        for (i = 0; i < cut; i++) send_byte(msg_bytes[i], i == cut - 1);
        sent += cut;
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
